/* hdl/mtom_pkg.sv */
// Shared types and constants for the motor thermal overload model.
`timescale 1ns / 1ps
package mtom_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int MAG_W     = SAMPLE_W + 1;
  localparam int SQ_W      = 31;
  localparam int HEAT_W    = 31;
  localparam int FRAC_BITS = 22;
  localparam int COEF_W    = FRAC_BITS + 1;
  localparam int MAC_ACC_W = HEAT_W + 2;
  localparam int RATE_W    = 9;
  localparam int RATE_SQ_W = 2 * RATE_W;
  localparam int FAULT_W   = 25;
  localparam int WARN_W    = 24;
  localparam int WPROD_W   = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = RATE_W;
  localparam int WACT_W    = 2;
  localparam int MODE_W    = 2;

  localparam logic [MAG_W-1:0]   RATED_Q10     = MAG_W'(1024);
  localparam logic [RATE_W-1:0]  LOAD_RATE_MAX = RATE_W'(400);
  localparam logic [FAULT_W-1:0] FAULT_FACTOR  = FAULT_W'(105);
  localparam logic [WPROD_W-1:0] WARN_FACTOR   = WPROD_W'(114);
  localparam int                 WARN_SHIFT    = 7;
  localparam logic [FAULT_W-1:0] DEFAULT_FAULT        = FAULT_W'(1388625);
  localparam logic [WARN_W-1:0]  DEFAULT_WARN_REDUCED = WARN_W'(1050000);
  localparam logic [WARN_W-1:0]  DEFAULT_WARN_NORMAL  = WARN_W'(1275750);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOAD_RATE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_REDUCED_WARN = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_PROT_MODE    = CFG_IDX_W'(2);

  // protection modes; any other code acts as fault only
  localparam logic [MODE_W-1:0] MODE_WARN_FAULT = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_OFF        = MODE_W'(1);

  typedef enum logic [WACT_W-1:0] {
    WACT_NONE  = 2'd0,
    WACT_RAISE = 2'd1,
    WACT_CLEAR = 2'd2
  } wact_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SQR  = 4'b0010,
    S_MAC  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  typedef struct packed {
    logic [FAULT_W-1:0] fault;
    logic [WARN_W-1:0]  warn;
  } thresh_t;

endpackage

/* hdl/mtom_in_if.sv */
// Current sample channel.
`timescale 1ns / 1ps
interface mtom_in_if;
  import mtom_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] current_sample;
  modport source (output valid, output current_sample, input ready);
  modport sink   (input valid, input current_sample, output ready);
endinterface

/* hdl/mtom_out_if.sv */
// Heat result channel.
`timescale 1ns / 1ps
interface mtom_out_if;
  import mtom_pkg::*;
  logic              valid;
  logic              ready;
  logic [HEAT_W-1:0] heat_level;
  logic [WACT_W-1:0] warn_action;
  logic              fault_raised;
  modport source (output valid, output heat_level, output warn_action, output fault_raised,
                  input ready);
  modport sink   (input valid, input heat_level, input warn_action, input fault_raised,
                  output ready);
endinterface

/* hdl/mtom_cfg_if.sv */
// Configuration write channel.
`timescale 1ns / 1ps
interface mtom_cfg_if;
  import mtom_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/motor_thermal_overload_model.sv */
// Top level of the I2t motor thermal overload model.
//
//   port     dir   role            payload
//   in_ch    sink  current sample  current_sample (Q10, signed)
//   out_ch   src   heat result     heat_level, warn_action, fault_raised
//   cfg_ch   sink  register write  index, data
//
// From sample transfer to out_ch.valid: the serial squarer, then the serial
// filter (one coefficient bit at a time), with handoffs between them and into the output register.
// One sample at a time; in_ch.ready is high only between samples.
// The result sits in an output register, so the next sample is taken while
// out_ch is stalled; only the following commit waits for the result to leave.
// rst_n is synchronous; heat and residue clear, the long time constant is selected.
`timescale 1ns / 1ps
module motor_thermal_overload_model #(
  parameter int LONG_TIME_CONSTANT  = 40000,
  parameter int SHORT_TIME_CONSTANT = 35000,
  parameter int SAMPLE_PERIOD       = 1
) (
  input  logic       clk,
  input  logic       rst_n,
  mtom_in_if.sink    in_ch,
  mtom_out_if.source out_ch,
  mtom_cfg_if.sink   cfg_ch
);
  import mtom_pkg::*;

  localparam logic [63:0] ONE_Q   = 64'd1 << FRAC_BITS;
  localparam logic [63:0] TAU_L   = (LONG_TIME_CONSTANT < 1) ? 64'd1 : 64'(LONG_TIME_CONSTANT);
  localparam logic [63:0] TAU_S   = (SHORT_TIME_CONSTANT < 1) ? 64'd1
                                                              : 64'(SHORT_TIME_CONSTANT);
  localparam logic [63:0] B_L_RAW = (64'(SAMPLE_PERIOD) << FRAC_BITS) / TAU_L;
  localparam logic [63:0] B_S_RAW = (64'(SAMPLE_PERIOD) << FRAC_BITS) / TAU_S;
  localparam logic [63:0] B_L     = (B_L_RAW > ONE_Q) ? ONE_Q : B_L_RAW;
  localparam logic [63:0] B_S     = (B_S_RAW > ONE_Q) ? ONE_Q : B_S_RAW;
  localparam logic [COEF_W-1:0] COEF_B_L = COEF_W'(B_L);
  localparam logic [COEF_W-1:0] COEF_A_L = COEF_W'(ONE_Q - B_L);
  localparam logic [COEF_W-1:0] COEF_B_S = COEF_W'(B_S);
  localparam logic [COEF_W-1:0] COEF_A_S = COEF_W'(ONE_Q - B_S);

  state_t               state_r, state_nxt;
  logic [RATE_W-1:0]    load_rate_r;
  logic                 reduced_warn_r;
  logic [MODE_W-1:0]    mode_r;
  logic [HEAT_W-1:0]    heat_r;
  logic [FRAC_BITS-1:0] residue_r;
  logic                 long_sel_r;
  logic                 rated_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [HEAT_W-1:0]    out_heat_r;
  wact_t                out_wact_r;
  logic                 out_fault_r;

  logic [SAMPLE_W-1:0]  raw;
  logic [MAG_W-1:0]     in_mag;
  logic                 in_xfer;
  logic                 sqr_done;
  logic [SQ_W-1:0]      sq;
  logic                 mac_done;
  logic [HEAT_W-1:0]    heat_new;
  logic [FRAC_BITS-1:0] residue_new;
  thresh_t              thresh;
  logic                 commit;
  wact_t                wact;
  logic                 fault;

  assign raw     = in_ch.current_sample;
  assign in_mag  = raw[SAMPLE_W-1] ? ({1'b0, ~raw} + MAG_W'(1)) : {1'b0, raw};
  // no transfer is taken while reset is held
  assign in_ch.ready = rst_n && (state_r == S_IDLE);
  assign in_xfer = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = rst_n;

  mtom_sqr u_sqr (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_xfer),
    .mag   (in_mag),
    .done  (sqr_done),
    .sq    (sq)
  );

  mtom_mac u_mac (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (sqr_done),
    .heat        (heat_r),
    .sq          (sq),
    .residue     (residue_r),
    .coef_a      (long_sel_r ? COEF_A_L : COEF_A_S),
    .coef_b      (long_sel_r ? COEF_B_L : COEF_B_S),
    .done        (mac_done),
    .heat_new    (heat_new),
    .residue_new (residue_new)
  );

  mtom_thr u_thr (
    .clk          (clk),
    .load_rate    (load_rate_r),
    .reduced_warn (reduced_warn_r),
    .thresh       (thresh)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_xfer) state_nxt = S_SQR;
      S_SQR:   if (sqr_done) state_nxt = S_MAC;
      S_MAC:   if (mac_done) state_nxt = S_DONE;
      S_DONE:  if (commit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // commit once the output register is free or being emptied
  assign commit = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    wact  = WACT_NONE;
    fault = 1'b0;
    if (mode_r != MODE_OFF) begin
      if (mode_r == MODE_WARN_FAULT && heat_new >= HEAT_W'(thresh.warn)) begin
        wact = WACT_RAISE;
      end else begin
        wact = WACT_CLEAR;
      end
      fault = (heat_new >= HEAT_W'(thresh.fault));
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      load_rate_r    <= '0;
      reduced_warn_r <= 1'b0;
      mode_r         <= MODE_WARN_FAULT;
      heat_r         <= '0;
      residue_r      <= '0;
      long_sel_r     <= 1'b1;
      out_valid_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        unique case (cfg_ch.index)
          CFG_LOAD_RATE:    load_rate_r    <= cfg_ch.data;
          CFG_REDUCED_WARN: reduced_warn_r <= cfg_ch.data[0];
          CFG_PROT_MODE:    mode_r         <= cfg_ch.data[MODE_W-1:0];
          default:          ;
        endcase
      end
      if (commit) begin
        heat_r     <= heat_new;
        residue_r  <= residue_new;
        long_sel_r <= rated_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rated_r <= (in_mag >= RATED_Q10);
    end
    if (commit) begin
      out_heat_r  <= heat_new;
      out_wact_r  <= wact;
      out_fault_r <= fault;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.heat_level   = out_heat_r;
  assign out_ch.warn_action  = out_wact_r;
  assign out_ch.fault_raised = out_fault_r;

endmodule

/* hdl/mtom_sqr.sv */
// Bit-serial squarer for the current magnitude, one multiplier bit per cycle.
`timescale 1ns / 1ps
module mtom_sqr (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [mtom_pkg::MAG_W-1:0] mag,
  output logic                      done,
  output logic [mtom_pkg::SQ_W-1:0]  sq
);
  import mtom_pkg::*;

  localparam int CNT_W = $clog2(MAG_W);
  localparam int ACC_W = MAG_W + 1;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [MAG_W-1:0] mcand_r, mcand_nxt;
  logic [MAG_W-1:0] mul_r, mul_nxt;
  logic [MAG_W-1:0] low_r, low_nxt;
  logic [ACC_W-1:0] sum;

  assign sum = acc_r + (mul_r[0] ? {1'b0, mcand_r} : '0);

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    mcand_nxt = mcand_r;
    mul_nxt   = mul_r;
    low_nxt   = low_r;
    if (start) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = '0;
      acc_nxt   = '0;
      mcand_nxt = mag;
      mul_nxt   = mag;
    end else if (busy_r) begin
      // product bit leaves at the bottom, partial sum shifts down
      acc_nxt = sum >> 1;
      low_nxt = {sum[0], low_r[MAG_W-1:1]};
      mul_nxt = mul_r >> 1;
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(MAG_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    mcand_r <= mcand_nxt;
    mul_r   <= mul_nxt;
    low_r   <= low_nxt;
  end

  assign done = done_r;
  assign sq   = {acc_r[SQ_W-MAG_W-1:0], low_r};

endmodule

/* hdl/mtom_mac.sv */
// Bit-serial I2t filter: heat*a + sq*b + residue, one coefficient bit per cycle.
`timescale 1ns / 1ps
module mtom_mac (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [mtom_pkg::HEAT_W-1:0]    heat,
  input  logic [mtom_pkg::SQ_W-1:0]      sq,
  input  logic [mtom_pkg::FRAC_BITS-1:0] residue,
  input  logic [mtom_pkg::COEF_W-1:0]    coef_a,
  input  logic [mtom_pkg::COEF_W-1:0]    coef_b,
  output logic                           done,
  output logic [mtom_pkg::HEAT_W-1:0]    heat_new,
  output logic [mtom_pkg::FRAC_BITS-1:0] residue_new
);
  import mtom_pkg::*;

  localparam int CNT_W = $clog2(COEF_W);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [MAC_ACC_W-1:0] acc_r, acc_nxt;
  logic [HEAT_W-1:0]    heat_op_r, heat_op_nxt;
  logic [SQ_W-1:0]      sq_op_r, sq_op_nxt;
  logic [COEF_W-1:0]    ca_r, ca_nxt;
  logic [COEF_W-1:0]    cb_r, cb_nxt;
  logic [FRAC_BITS-1:0] res_r, res_nxt;
  logic [COEF_W-1:0]    low_r, low_nxt;
  logic [MAC_ACC_W-1:0] sum;

  // residue bit i enters at weight 2^i, same as the coefficient bits
  assign sum = acc_r
             + (ca_r[0] ? MAC_ACC_W'(heat_op_r) : '0)
             + (cb_r[0] ? MAC_ACC_W'(sq_op_r) : '0)
             + MAC_ACC_W'(res_r[0]);

  always_comb begin
    busy_nxt    = busy_r;
    done_nxt    = 1'b0;
    cnt_nxt     = cnt_r;
    acc_nxt     = acc_r;
    heat_op_nxt = heat_op_r;
    sq_op_nxt   = sq_op_r;
    ca_nxt      = ca_r;
    cb_nxt      = cb_r;
    res_nxt     = res_r;
    low_nxt     = low_r;
    if (start) begin
      busy_nxt    = 1'b1;
      cnt_nxt     = '0;
      acc_nxt     = '0;
      heat_op_nxt = heat;
      sq_op_nxt   = sq;
      ca_nxt      = coef_a;
      cb_nxt      = coef_b;
      res_nxt     = residue;
    end else if (busy_r) begin
      acc_nxt = sum >> 1;
      low_nxt = {sum[0], low_r[COEF_W-1:1]};
      ca_nxt  = ca_r >> 1;
      cb_nxt  = cb_r >> 1;
      res_nxt = res_r >> 1;
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(COEF_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r     <= acc_nxt;
    heat_op_r <= heat_op_nxt;
    sq_op_r   <= sq_op_nxt;
    ca_r      <= ca_nxt;
    cb_r      <= cb_nxt;
    res_r     <= res_nxt;
    low_r     <= low_nxt;
  end

  assign done        = done_r;
  // low_r holds sum bits [22:0]; acc_r holds sum >> 23
  assign heat_new    = {acc_r[HEAT_W-2:0], low_r[COEF_W-1]};
  assign residue_new = low_r[FRAC_BITS-1:0];

endmodule

/* hdl/mtom_thr.sv */
// Warning and fault thresholds from the load-rate and reduced-warning settings, three register stages.
`timescale 1ns / 1ps
module mtom_thr (
  input  logic                        clk,
  input  logic [mtom_pkg::RATE_W-1:0] load_rate,
  input  logic                        reduced_warn,
  output mtom_pkg::thresh_t           thresh
);
  import mtom_pkg::*;

  logic [RATE_W-1:0]    rate_sat;
  logic [RATE_SQ_W-1:0] rsq_r;
  logic [FAULT_W-1:0]   fault_p_r;
  logic [WPROD_W-1:0]   warn_prod;
  logic                 zero1_r, zero2_r;
  logic                 red1_r, red2_r;
  thresh_t              thresh_r;

  assign rate_sat  = (load_rate > LOAD_RATE_MAX) ? LOAD_RATE_MAX : load_rate;
  assign warn_prod = WPROD_W'(fault_p_r) * WARN_FACTOR;

  always_ff @(posedge clk) begin
    rsq_r     <= RATE_SQ_W'(rate_sat) * RATE_SQ_W'(rate_sat);
    zero1_r   <= (load_rate == '0);
    red1_r    <= reduced_warn;
    fault_p_r <= FAULT_W'(rsq_r) * FAULT_FACTOR;
    zero2_r   <= zero1_r;
    red2_r    <= red1_r;
    if (zero2_r) begin
      thresh_r.fault <= DEFAULT_FAULT;
      thresh_r.warn  <= red2_r ? DEFAULT_WARN_REDUCED : DEFAULT_WARN_NORMAL;
    end else begin
      thresh_r.fault <= fault_p_r;
      thresh_r.warn  <= warn_prod[WARN_SHIFT+WARN_W-1:WARN_SHIFT];
    end
  end

  assign thresh = thresh_r;

endmodule

/* dv/mtom_heat_checker.sv */
// Checker that predicts every heat result from the observed samples and compares it.
`timescale 1ns / 1ps
module mtom_heat_checker
  import mtom_pkg::*;
#(
  parameter int LONG_TIME_CONSTANT  = 40000,
  parameter int SHORT_TIME_CONSTANT = 35000,
  parameter int SAMPLE_PERIOD       = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  mtom_in_if                in_ch,
  mtom_out_if               out_ch,
  mtom_cfg_if               cfg_ch,
  output int                mismatches,
  output int                pending,
  output int                checked,
  output int                raises,
  output int                faults,
  output logic [HEAT_W-1:0] heat_now
);

  localparam longint unsigned ONE_Q22 = 64'd1 << FRAC_BITS;

  typedef struct packed {
    logic [HEAT_W-1:0] heat_level;
    wact_t             warn_action;
    logic              fault_raised;
  } heat_result_t;

  heat_result_t expected_heat_q[$];
  heat_result_t want;

  // shadow of the register file
  logic [RATE_W-1:0] load_rate;
  logic              reduced_warn;
  logic [MODE_W-1:0] prot_mode;

  // filter state
  longint unsigned heat_acc;
  longint unsigned residue;
  logic            long_tc_sel;

  int err_cnt, chk_cnt, raise_cnt, fault_cnt;

  // One filter step: updates the heat state and returns the result it yields.
  function automatic heat_result_t advance_heat(input logic [SAMPLE_W-1:0] smp);
    logic [MAG_W-1:0] mag;
    longint unsigned  sq, tau, gain_b, gain_a, acc, rate, fault_th, warn_th;
    heat_result_t     res;
    mag = smp[SAMPLE_W-1] ? (MAG_W'(1 << SAMPLE_W) - MAG_W'(smp)) : MAG_W'(smp);
    sq  = 64'(mag) * 64'(mag);
    tau = long_tc_sel ? 64'(LONG_TIME_CONSTANT) : 64'(SHORT_TIME_CONSTANT);
    if (tau == 0) tau = 1;
    gain_b = (64'(SAMPLE_PERIOD) << FRAC_BITS) / tau;
    if (gain_b > ONE_Q22) gain_b = ONE_Q22;
    gain_a = ONE_Q22 - gain_b;
    // remainder below the Q22 point is carried into the next step
    acc      = heat_acc * gain_a + sq * gain_b + residue;
    heat_acc = (acc >> FRAC_BITS) & 64'h7FFF_FFFF;
    residue  = acc & (ONE_Q22 - 1);
    if (load_rate != '0) begin
      rate     = (load_rate > LOAD_RATE_MAX) ? 64'(LOAD_RATE_MAX) : 64'(load_rate);
      fault_th = rate * rate * 64'(FAULT_FACTOR);
      warn_th  = (fault_th * 64'(WARN_FACTOR)) >> WARN_SHIFT;
    end else begin
      fault_th = 64'(DEFAULT_FAULT);
      warn_th  = reduced_warn ? 64'(DEFAULT_WARN_REDUCED) : 64'(DEFAULT_WARN_NORMAL);
    end
    res.heat_level   = HEAT_W'(heat_acc);
    res.warn_action  = WACT_NONE;
    res.fault_raised = 1'b0;
    if (prot_mode != MODE_OFF) begin
      if (prot_mode == MODE_WARN_FAULT && heat_acc >= warn_th) begin
        res.warn_action = WACT_RAISE;
      end else begin
        res.warn_action = WACT_CLEAR;
      end
      res.fault_raised = (heat_acc >= fault_th);
    end
    long_tc_sel = (mag >= RATED_Q10);
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_heat_q.delete();
      load_rate    = '0;
      reduced_warn = 1'b0;
      prot_mode    = MODE_WARN_FAULT;
      heat_acc     = 0;
      residue      = 0;
      long_tc_sel  = 1'b1;
      err_cnt      = 0;
      chk_cnt      = 0;
      raise_cnt    = 0;
      fault_cnt    = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_LOAD_RATE:    load_rate    = cfg_ch.data;
          CFG_REDUCED_WARN: reduced_warn = cfg_ch.data[0];
          CFG_PROT_MODE:    prot_mode    = cfg_ch.data[MODE_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_heat_q.push_back(advance_heat(in_ch.current_sample));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_heat_q.size() == 0) begin
          $error("heat result transfer with no sample outstanding: heat_level %0d",
                 out_ch.heat_level);
          err_cnt++;
        end else begin
          want = expected_heat_q.pop_front();
          chk_cnt++;
          if (want.warn_action == WACT_RAISE) raise_cnt++;
          if (want.fault_raised) fault_cnt++;
          if (out_ch.heat_level !== want.heat_level) begin
            $error("heat_level: expected %0d, actual %0d", want.heat_level, out_ch.heat_level);
            err_cnt++;
          end
          if (out_ch.warn_action !== want.warn_action) begin
            $error("warn_action: expected %0d, actual %0d", want.warn_action,
                   out_ch.warn_action);
            err_cnt++;
          end
          if (out_ch.fault_raised !== want.fault_raised) begin
            $error("fault_raised: expected %0d, actual %0d", want.fault_raised,
                   out_ch.fault_raised);
            err_cnt++;
          end
        end
      end
    end
    mismatches <= err_cnt;
    pending    <= expected_heat_q.size();
    checked    <= chk_cnt;
    raises     <= raise_cnt;
    faults     <= fault_cnt;
    heat_now   <= HEAT_W'(heat_acc);
  end

endmodule

/* dv/testbench.sv */
// Testbench top: drives samples and register writes into the overload model, gives the verdict.
`timescale 1ns / 1ps
module testbench;
  import mtom_pkg::*;

  localparam int LONG_TC     = 40000;
  localparam int SHORT_TC    = 35000;
  localparam int PERIOD_MS   = 1;
  localparam int N_RANDOM    = 2000;
  localparam int CYCLE_LIMIT = 1_200_000;
  localparam int HOLD_CYCLES = 600;
  localparam int DRAIN_TAIL  = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED      = CFG_IDX_W'(3);
  localparam logic [MODE_W-1:0]    MODE_FAULT_ONLY = MODE_W'(2);
  localparam logic [MODE_W-1:0]    MODE_SPARE      = MODE_W'(3);

  typedef enum int {DRIVE_LIGHT, DRIVE_RATED, DRIVE_HEAVY, DRIVE_ANY} drive_t;

  logic clk;
  logic rst_n;

  mtom_in_if  in_if ();
  mtom_out_if out_if ();
  mtom_cfg_if cfg_if ();

  int              mismatches, pending, checked, raises, faults;
  logic [HEAT_W-1:0] heat_now;
  int              sent, directed_sent, random_sent, cfg_writes, settings, burst_left;
  int              cycle_count;
  bit              hold_off_req;

  motor_thermal_overload_model #(
    .LONG_TIME_CONSTANT (LONG_TC),
    .SHORT_TIME_CONSTANT(SHORT_TC),
    .SAMPLE_PERIOD      (PERIOD_MS)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if),
    .cfg_ch(cfg_if)
  );

  mtom_heat_checker #(
    .LONG_TIME_CONSTANT (LONG_TC),
    .SHORT_TIME_CONSTANT(SHORT_TC),
    .SAMPLE_PERIOD      (PERIOD_MS)
  ) u_heat_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_ch    (cfg_if),
    .mismatches(mismatches),
    .pending   (pending),
    .checked   (checked),
    .raises    (raises),
    .faults    (faults),
    .heat_now  (heat_now)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // valid stays up after the transfer; the caller lowers it on a gap
  task automatic push_sample(input logic signed [SAMPLE_W-1:0] smp);
    in_if.valid          <= 1'b1;
    in_if.current_sample <= smp;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp);
    int gap;
    push_sample(smp);
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 60);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val,
                           input bit last);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_writes++;
    if (last) cfg_if.valid <= 1'b0;
  endtask

  // hold the input side until every outstanding result has come back
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(input drive_t drive);
    int mag;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      case ($urandom_range(0, 6))
        0:       return SAMPLE_W'(-32768);
        1:       return SAMPLE_W'(32767);
        2:       return SAMPLE_W'(0);
        3:       return SAMPLE_W'(1023);
        4:       return SAMPLE_W'(1024);
        5:       return SAMPLE_W'(-1023);
        default: return SAMPLE_W'(-1024);
      endcase
    end
    if (roll < 12) return SAMPLE_W'($urandom);
    case (drive)
      DRIVE_LIGHT: mag = $urandom_range(0, 1023);
      DRIVE_RATED: mag = $urandom_range(900, 1400);
      DRIVE_HEAVY: mag = $urandom_range(3000, 32767);
      default:     mag = $urandom_range(0, 32767);
    endcase
    return $urandom_range(0, 1) ? SAMPLE_W'(-mag) : SAMPLE_W'(mag);
  endfunction

  task automatic set_phase_config(input int phase);
    logic [CFG_DAT_W-1:0] rate;
    logic [CFG_DAT_W-1:0] reduced;
    logic [CFG_DAT_W-1:0] mode;
    real                  near;
    // upper data bits are noise; only the low bits of the narrow registers count
    reduced = CFG_DAT_W'($urandom);
    mode    = {7'($urandom), MODE_W'($urandom_range(0, 3))};
    case ($urandom_range(0, 7))
      0:       rate = '0;
      1:       rate = CFG_DAT_W'(1);
      2:       rate = CFG_DAT_W'(400);
      3:       rate = CFG_DAT_W'($urandom_range(401, 511));
      4:       rate = CFG_DAT_W'($urandom_range(2, 60));
      default: begin
        // put the warning threshold just above the present heat
        near = $sqrt(real'(heat_now) / (105.0 * 0.89));
        rate = (near > 395.0) ? CFG_DAT_W'(400) : CFG_DAT_W'(int'(near) + $urandom_range(1, 4));
      end
    endcase
    case (phase)
      0: begin rate = '0; reduced[0] = 1'b0; mode = CFG_DAT_W'(MODE_WARN_FAULT); end
      1: begin rate = '0; reduced[0] = 1'b1; mode = CFG_DAT_W'(MODE_WARN_FAULT); end
      2: begin rate = CFG_DAT_W'(400); mode = CFG_DAT_W'(MODE_WARN_FAULT); end
      3: begin rate = CFG_DAT_W'(511); mode = CFG_DAT_W'(MODE_WARN_FAULT); end
      4: begin rate = CFG_DAT_W'(1); mode = CFG_DAT_W'(MODE_FAULT_ONLY); end
      5: begin rate = CFG_DAT_W'(1); mode = CFG_DAT_W'(MODE_WARN_FAULT); end
      6: mode[MODE_W-1:0] = MODE_OFF;
      7: mode[MODE_W-1:0] = MODE_SPARE;
      default: ;
    endcase
    write_reg(CFG_LOAD_RATE, rate, 1'b0);
    write_reg(CFG_REDUCED_WARN, reduced, 1'b0);
    write_reg(CFG_PROT_MODE, mode, 1'b1);
    settings++;
  endtask

  // result side: changing stall patterns, plus a long hold-off on request
  initial begin : result_sink
    int pat_left;
    int pat;
    int held;
    pat_left = 0;
    pat      = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_if.ready <= 1'b0;
        for (held = 1; held < HOLD_CYCLES; held++) @(posedge clk);
      end else begin
        if (pat_left == 0) begin
          pat      = $urandom_range(0, 3);
          pat_left = $urandom_range(20, 200);
        end
        pat_left--;
        case (pat)
          0:       out_if.ready <= 1'b1;
          1:       out_if.ready <= 1'($urandom_range(0, 1));
          2:       out_if.ready <= ($urandom_range(0, 7) != 0);
          default: out_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $error("run stopped after %0d cycles, %0d results outstanding", CYCLE_LIMIT, pending);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    logic signed [SAMPLE_W-1:0] opening [12];
    drive_t                     drive;
    int                         phase;
    int                         phase_len;
    int                         drive_left;
    int                         k;
    hold_off_req = 1'b0;
    sent         = 0;
    random_sent  = 0;
    cfg_writes   = 0;
    settings     = 1;
    burst_left   = 1;
    rst_n                <= 1'b0;
    in_if.valid          <= 1'b0;
    in_if.current_sample <= '0;
    cfg_if.valid         <= 1'b0;
    cfg_if.index         <= CFG_LOAD_RATE;
    cfg_if.data          <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: small and boundary currents, both time constants, both signs
    opening = '{SAMPLE_W'(0), SAMPLE_W'(1), SAMPLE_W'(-1), SAMPLE_W'(1023), SAMPLE_W'(1024),
                SAMPLE_W'(-1024), SAMPLE_W'(-1023), SAMPLE_W'(32767), SAMPLE_W'(-32768),
                SAMPLE_W'(-32768), SAMPLE_W'(16'h5555), SAMPLE_W'(16'hAAAA)};
    foreach (opening[i]) send_sample(opening[i]);

    wait_drained();
    write_reg(CFG_PROT_MODE, CFG_DAT_W'(MODE_OFF), 1'b1);
    settings++;
    send_sample(SAMPLE_W'(32767));
    send_sample(SAMPLE_W'(-32768));

    wait_drained();
    write_reg(CFG_PROT_MODE, CFG_DAT_W'(MODE_FAULT_ONLY), 1'b1);
    settings++;
    send_sample(SAMPLE_W'(-32768));
    send_sample(SAMPLE_W'(500));

    wait_drained();
    write_reg(CFG_PROT_MODE, {7'h7F, MODE_SPARE}, 1'b1);
    settings++;
    send_sample(SAMPLE_W'(32767));
    send_sample(SAMPLE_W'(-2));

    // saturating load rate; a write to the unused index changes nothing
    wait_drained();
    write_reg(CFG_LOAD_RATE, CFG_DAT_W'(511), 1'b0);
    write_reg(CFG_REDUCED_WARN, CFG_DAT_W'(9'h1FF), 1'b0);
    write_reg(CFG_UNUSED, CFG_DAT_W'($urandom), 1'b0);
    write_reg(CFG_PROT_MODE, CFG_DAT_W'(MODE_WARN_FAULT), 1'b1);
    settings++;
    send_sample(SAMPLE_W'(32767));
    send_sample(SAMPLE_W'(-32768));
    send_sample(SAMPLE_W'(1024));
    directed_sent = sent;

    phase = 0;
    while (random_sent < N_RANDOM) begin
      wait_drained();
      set_phase_config(phase);
      if (phase == 2 || phase == 9) begin
        hold_off_req = 1'b1;
        burst_left   = 40;
      end
      phase_len  = $urandom_range(100, 220);
      drive_left = 0;
      for (k = 0; k < phase_len; k++) begin
        if (drive_left == 0) begin
          drive      = drive_t'($urandom_range(0, 3));
          drive_left = $urandom_range(15, 80);
        end
        drive_left--;
        send_sample(pick_sample(drive));
        random_sent++;
        if ($urandom_range(0, 199) == 0) wait_drained();
      end
      phase++;
    end

    wait_drained();
    repeat (DRAIN_TAIL) @(posedge clk);
    $display("Run covered %0d current samples (%0d directed), %0d register writes, %0d settings.",
             sent, directed_sent, cfg_writes, settings);
    $display("Compared %0d heat results: warning raised on %0d, fault on %0d.",
             checked, raises, faults);
    if (mismatches == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* motor_thermal_overload_model.f */
hdl/mtom_pkg.sv
hdl/mtom_in_if.sv
hdl/mtom_out_if.sv
hdl/mtom_cfg_if.sv
hdl/mtom_sqr.sv
hdl/mtom_mac.sv
hdl/mtom_thr.sv
hdl/motor_thermal_overload_model.sv
dv/mtom_heat_checker.sv
dv/testbench.sv
